// ===== design/variable_range_memory_type_lookup_defines.svh =====
// Assertion macros shared by the checker of the memory-type range table.
`ifndef VARIABLE_RANGE_MEMORY_TYPE_LOOKUP_DEFINES_SVH
`define VARIABLE_RANGE_MEMORY_TYPE_LOOKUP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VRMT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define VRMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== design/vrmt_pkg.sv =====
// Types and constants of the variable memory-type range table.
package vrmt_pkg;

  localparam int unsigned RangeEntriesDefault = 16;
  localparam int unsigned FrameW = 40;
  localparam int unsigned FrameShift = 12;
  localparam int unsigned AddrW = FrameW + FrameShift;
  localparam int unsigned BoundW = AddrW + 1;
  localparam int unsigned TypeW = 8;
  localparam int unsigned IndexW = 4;
  localparam logic [BoundW-1:0] PageSpanM1 = BoundW'(64'h1F_FFFF);

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } vrmt_cmd_e;

  typedef struct packed {
    logic              valid;
    logic [AddrW-1:0]  page;
    logic [BoundW-1:0] page_end;
    logic [TypeW-1:0]  result;
  } vrmt_token_t;

  typedef struct packed {
    logic [AddrW-1:0]  lo;
    logic [BoundW-1:0] hi;
    logic [TypeW-1:0]  range_type;
    logic              enable;
  } vrmt_load_t;

endpackage

// ===== design/vrmt_cell.sv =====
// One range entry that checks a passing query token and hands it on.
module vrmt_cell import vrmt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        we_i,
  input  vrmt_load_t  load_i,
  input  vrmt_token_t tok_i,
  output vrmt_token_t tok_o
);

  logic              en_q;
  logic [AddrW-1:0]  lo_q;
  logic [BoundW-1:0] hi_q;
  logic [TypeW-1:0]  type_q;
  logic              valid_q;
  vrmt_token_t       tok_d;
  vrmt_token_t       tok_q;
  logic              hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b0;
    end else if (we_i) begin
      en_q <= load_i.enable;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      lo_q   <= load_i.lo;
      hi_q   <= load_i.hi;
      type_q <= load_i.range_type;
    end
  end

  always_comb begin
    hit = en_q && (tok_i.page_end >= {1'b0, lo_q}) && ({1'b0, tok_i.page} <= hi_q);
    tok_d = tok_i;
    if (hit) begin
      tok_d.result = type_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  always_comb begin
    tok_o = tok_q;
    tok_o.valid = valid_q;
  end

endmodule

// ===== design/variable_range_memory_type_lookup.sv =====
// Top level of the variable memory-type range table.
// A load beat writes one entry and returns nothing. A query beat walks a row of
// RANGE_ENTRIES cells, one cell per cycle, through the register of each cell. busy is
// set by a taken query and falls in the cycle after the result strobe, and no new beat
// is taken while busy is high. The strobe lasts one cycle and cannot be
// held off by the receiver.
module variable_range_memory_type_lookup import vrmt_pkg::*; #(
  parameter int unsigned RANGE_ENTRIES = RangeEntriesDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              command_i,
  input  logic [IndexW-1:0] entry_index_i,
  input  logic [FrameW-1:0] base_frame_i,
  input  logic [FrameW-1:0] mask_frame_i,
  input  logic [TypeW-1:0]  range_type_in_i,
  input  logic              range_valid_in_i,
  input  logic [AddrW-1:0]  page_address_i,
  input  logic [TypeW-1:0]  candidate_type_i,
  output logic              result_valid_o,
  output logic [TypeW-1:0]  effective_type_o
);

  logic              accept;
  logic              load_go;
  logic              busy_d;
  logic              busy_q;
  logic [FrameW-1:0] low_bit;
  logic [FrameW-1:0] span_frames_m1;
  logic [FrameW:0]   hi_frame;
  vrmt_load_t        load;
  vrmt_token_t       tok [0:RANGE_ENTRIES];

  assign accept  = start && !busy_q;
  assign load_go = accept && (command_i == CMD_LOAD);

  always_comb begin
    low_bit        = mask_frame_i & (~mask_frame_i + FrameW'(1));
    span_frames_m1 = low_bit - FrameW'(1);
    hi_frame       = {1'b0, base_frame_i} + {1'b0, span_frames_m1};
    load.lo        = {base_frame_i, {FrameShift{1'b0}}};
    if (mask_frame_i != '0) begin
      load.hi = {hi_frame, {FrameShift{1'b1}}};
    end else begin
      load.hi = {1'b0, base_frame_i, {FrameShift{1'b0}}};
    end
    load.range_type = range_type_in_i;
    load.enable     = range_valid_in_i;
  end

  always_comb begin
    tok[0].valid    = accept && (command_i == CMD_QUERY);
    tok[0].page     = page_address_i;
    tok[0].page_end = {1'b0, page_address_i} + PageSpanM1;
    tok[0].result   = candidate_type_i;
  end

  for (genvar k = 0; k < RANGE_ENTRIES; k++) begin : g_cell
    vrmt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .we_i   (load_go && (int'(entry_index_i) == k)),
      .load_i (load),
      .tok_i  (tok[k]),
      .tok_o  (tok[k+1])
    );
  end

  always_comb begin
    busy_d = busy_q;
    if (tok[0].valid) begin
      busy_d = 1'b1;
    end else if (tok[RANGE_ENTRIES].valid) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  assign busy             = busy_q;
  assign result_valid_o   = tok[RANGE_ENTRIES].valid;
  assign effective_type_o = tok[RANGE_ENTRIES].result;

endmodule

// ===== design/vrmt_checker.sv =====
// Port-level checks of the memory-type range table and their binding.
`include "variable_range_memory_type_lookup_defines.svh"

module vrmt_checker import vrmt_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic command_i,
  input logic result_valid_o
);

  logic query_go;
  logic load_go;

  assign query_go = start && !busy && (command_i == CMD_QUERY);
  assign load_go  = start && !busy && (command_i == CMD_LOAD);

  `VRMT_ASSERT_IMPL(a_strobe_while_busy, clk_i, rst_ni, result_valid_o, busy)
  `VRMT_ASSERT_NEXT(a_query_sets_busy, clk_i, rst_ni, query_go, busy)
  `VRMT_ASSERT_NEXT(a_load_stays_idle, clk_i, rst_ni, load_go, !busy)
  `VRMT_ASSERT_NEXT(a_strobe_frees, clk_i, rst_ni, result_valid_o, !busy && !result_valid_o)

endmodule

bind variable_range_memory_type_lookup vrmt_checker u_vrmt_checker (.*);

// ===== sim/variable_range_memory_type_lookup_tb.sv =====
// Self-checking testbench of the variable memory-type range table, with its own predictor.
`timescale 1ns / 100ps

module variable_range_memory_type_lookup_tb;
  import vrmt_pkg::*;

  localparam int unsigned Entries = RangeEntriesDefault;
  localparam int unsigned RandomBeats = 1030;
  localparam int unsigned StallLimit = 2000;
  localparam logic [63:0] PageBytesM1 = 64'h1F_FFFF;
  localparam logic [63:0] AddrMask = (64'd1 << AddrW) - 64'd1;

  typedef struct {
    vrmt_cmd_e         cmd;
    logic [IndexW-1:0] idx;
    logic [FrameW-1:0] base;
    logic [FrameW-1:0] mask;
    logic [TypeW-1:0]  rtype;
    logic              rvalid;
    logic [AddrW-1:0]  page;
    logic [TypeW-1:0]  cand;
    bit                typed;
    logic [TypeW-1:0]  want;
  } mtype_beat_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic              command_i;
  logic [IndexW-1:0] entry_index_i;
  logic [FrameW-1:0] base_frame_i;
  logic [FrameW-1:0] mask_frame_i;
  logic [TypeW-1:0]  range_type_in_i;
  logic              range_valid_in_i;
  logic [AddrW-1:0]  page_address_i;
  logic [TypeW-1:0]  candidate_type_i;
  logic              result_valid_o;
  logic [TypeW-1:0]  effective_type_o;

  logic [63:0]      lo_bound [Entries];
  logic [63:0]      hi_bound [Entries];
  logic [TypeW-1:0] type_of  [Entries];
  bit               enabled  [Entries];

  logic [TypeW-1:0] type_expect_q [$];
  mtype_beat_t      directed_q [$];
  logic [TypeW-1:0] got_type;
  int               fail_count = 0;
  int               stall_cycles = 0;

  variable_range_memory_type_lookup #(
    .RANGE_ENTRIES(Entries)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .command_i       (command_i),
    .entry_index_i   (entry_index_i),
    .base_frame_i    (base_frame_i),
    .mask_frame_i    (mask_frame_i),
    .range_type_in_i (range_type_in_i),
    .range_valid_in_i(range_valid_in_i),
    .page_address_i  (page_address_i),
    .candidate_type_i(candidate_type_i),
    .result_valid_o  (result_valid_o),
    .effective_type_o(effective_type_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void load_range(mtype_beat_t b);
    int          low_bit;
    logic [63:0] span_m1;
    low_bit = -1;
    span_m1 = 64'd0;
    if (b.idx < Entries) begin
      for (int n = FrameW - 1; n >= 0; n--) begin
        if (b.mask[n]) low_bit = n;
      end
      if (low_bit >= 0) span_m1 = (64'd1 << (low_bit + FrameShift)) - 64'd1;
      lo_bound[b.idx] = {24'd0, b.base} << FrameShift;
      hi_bound[b.idx] = ({24'd0, b.base} << FrameShift) + span_m1;
      type_of[b.idx] = b.rtype;
      enabled[b.idx] = b.rvalid;
    end
  endfunction

  function automatic logic [TypeW-1:0] lookup_type(logic [AddrW-1:0] page,
                                                   logic [TypeW-1:0] cand);
    logic [TypeW-1:0] found;
    logic [63:0]      first;
    found = cand;
    first = {12'd0, page};
    for (int k = 0; k < Entries; k++) begin
      if (enabled[k] && (first + PageBytesM1) >= lo_bound[k] && first <= hi_bound[k])
        found = type_of[k];
    end
    return found;
  endfunction

  function automatic mtype_beat_t random_beat();
    mtype_beat_t b;
    int          low_bit;
    int          k;
    logic [63:0] spot;
    b.cmd = ($urandom_range(0, 99) < 30) ? CMD_LOAD : CMD_QUERY;
    b.idx = IndexW'($urandom);
    b.base = ($urandom_range(0, 1) == 1) ? FrameW'({$urandom, $urandom})
                                         : FrameW'($urandom_range(0, 4096));
    low_bit = $urandom_range(0, FrameW);
    b.mask = (low_bit == FrameW) ? '0 : FrameW'(({$urandom, $urandom} | 64'd1) << low_bit);
    b.rtype = TypeW'($urandom);
    b.rvalid = ($urandom_range(0, 99) < 80);
    b.cand = TypeW'($urandom);
    b.typed = 1'b0;
    b.want = '0;
    k = $urandom_range(0, Entries - 1);
    case ($urandom_range(0, 6))
      0: spot = lo_bound[k] - PageBytesM1 - 64'd1;
      1: spot = lo_bound[k] - PageBytesM1;
      2: spot = hi_bound[k];
      3: spot = hi_bound[k] + 64'd1;
      4: spot = lo_bound[k] + ({$urandom, $urandom} & (hi_bound[k] - lo_bound[k]));
      default: spot = {$urandom, $urandom};
    endcase
    b.page = AddrW'(spot & AddrMask);
    return b;
  endfunction

  task automatic add_row(input vrmt_cmd_e cmd, input logic [IndexW-1:0] idx,
                         input logic [FrameW-1:0] base, input logic [FrameW-1:0] mask,
                         input logic [TypeW-1:0] rtype, input logic rvalid,
                         input logic [AddrW-1:0] page, input logic [TypeW-1:0] cand,
                         input bit typed, input logic [TypeW-1:0] want);
    mtype_beat_t b;
    b = '{cmd, idx, base, mask, rtype, rvalid, page, cand, typed, want};
    directed_q.push_back(b);
  endtask

  task automatic send_beat(input mtype_beat_t b, input bit may_idle);
    int gap;
    if (may_idle && $urandom_range(0, 99) < 37) begin
      start <= 1'b0;
      gap = $urandom_range(1, 20);
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    command_i <= b.cmd;
    entry_index_i <= b.idx;
    base_frame_i <= b.base;
    mask_frame_i <= b.mask;
    range_type_in_i <= b.rtype;
    range_valid_in_i <= b.rvalid;
    page_address_i <= b.page;
    candidate_type_i <= b.cand;
    do @(posedge clk_i); while (busy);
    if (b.cmd == CMD_QUERY)
      type_expect_q.push_back(b.typed ? b.want : lookup_type(b.page, b.cand));
    else
      load_range(b);
  endtask

  initial begin
    mtype_beat_t row;
    mtype_beat_t b;
    rst_ni <= 1'b0;
    start <= 1'b0;
    command_i <= CMD_LOAD;
    entry_index_i <= '0;
    base_frame_i <= '0;
    mask_frame_i <= '0;
    range_type_in_i <= '0;
    range_valid_in_i <= 1'b0;
    page_address_i <= '0;
    candidate_type_i <= '0;
    for (int k = 0; k < Entries; k++) begin
      lo_bound[k] = '0;
      hi_bound[k] = '0;
      type_of[k] = '0;
      enabled[k] = 1'b0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(CMD_QUERY, 0, 0, 0, 0, 0, 52'h0, 8'hA5, 1, 8'hA5);
    add_row(CMD_QUERY, 0, 0, 0, 0, 0, 52'hF_FFFF_FFFF_FFFF, 8'h00, 1, 8'h00);
    add_row(CMD_LOAD, 0, 40'h0, 40'h0, 8'h06, 1, 0, 0, 0, 0);
    add_row(CMD_QUERY, 0, 0, 0, 0, 0, 52'h0, 8'h00, 1, 8'h06);
    add_row(CMD_QUERY, 0, 0, 0, 0, 0, 52'h20_0000, 8'h11, 1, 8'h11);
    add_row(CMD_QUERY, 0, 0, 0, 0, 0, 52'h1, 8'h12, 0, 0);
    add_row(CMD_LOAD, 15, 40'hFF_FFFF_FFFF, 40'h80_0000_0000, 8'hFF, 1, 0, 0, 0, 0);
    add_row(CMD_QUERY, 0, 0, 0, 0, 0, 52'hF_FFFF_FFFF_FFFF, 8'h00, 1, 8'hFF);
    add_row(CMD_QUERY, 0, 0, 0, 0, 0, 52'hF_FFFF_FFDF_F000, 8'h33, 0, 0);
    add_row(CMD_QUERY, 0, 0, 0, 0, 0, 52'hF_FFFF_FFDF_F001, 8'h33, 0, 0);
    add_row(CMD_LOAD, 3, 40'h200, 40'h1, 8'h01, 0, 0, 0, 0, 0);
    add_row(CMD_QUERY, 0, 0, 0, 0, 0, 52'h20_0000, 8'h22, 1, 8'h22);
    add_row(CMD_LOAD, 3, 40'h200, 40'h3, 8'h01, 1, 0, 0, 0, 0);
    add_row(CMD_QUERY, 0, 0, 0, 0, 0, 52'h20_0000, 8'h22, 0, 0);
    add_row(CMD_QUERY, 0, 0, 0, 0, 0, 52'h20_1000, 8'h44, 0, 0);
    add_row(CMD_QUERY, 0, 0, 0, 0, 0, 52'h1000, 8'h44, 0, 0);
    add_row(CMD_LOAD, 5, 40'h0, 40'hFF_FFFF_FFFF, 8'h04, 1, 0, 0, 0, 0);
    add_row(CMD_QUERY, 0, 0, 0, 0, 0, 52'h0, 8'h00, 0, 0);
    add_row(CMD_LOAD, 5, 40'h0, 40'h0, 8'h00, 0, 0, 0, 0, 0);
    add_row(CMD_QUERY, 0, 0, 0, 0, 0, 52'h0, 8'h77, 0, 0);
    add_row(CMD_LOAD, 15, 40'h0, 40'h0, 8'h00, 0, 0, 0, 0, 0);
    add_row(CMD_QUERY, 0, 0, 0, 0, 0, 52'hF_FFFF_FFFF_FFFF, 8'hFF, 1, 8'hFF);

    // Fields that a command does not use carry random values.
    foreach (directed_q[i]) begin
      row = directed_q[i];
      b = random_beat();
      b.cmd = row.cmd;
      b.typed = row.typed;
      b.want = row.want;
      if (row.cmd == CMD_LOAD) begin
        b.idx = row.idx;
        b.base = row.base;
        b.mask = row.mask;
        b.rtype = row.rtype;
        b.rvalid = row.rvalid;
      end else begin
        b.page = row.page;
        b.cand = row.cand;
      end
      send_beat(b, 1'b1);
    end

    // Beats 300 to 499 go back to back.
    for (int i = 0; i < RandomBeats; i++) begin
      send_beat(random_beat(), !(i >= 300 && i < 500));
    end
    start <= 1'b0;

    while (type_expect_q.size() != 0) @(posedge clk_i);
    repeat (Entries + 8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("variable_range_memory_type_lookup verification clean");
    end else begin
      $display("variable_range_memory_type_lookup verification failed");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (type_expect_q.size() == 0) begin
        $error("effective_type: no result expected, actual %0h", effective_type_o);
        fail_count++;
      end else begin
        got_type = type_expect_q.pop_front();
        if (effective_type_o !== got_type) begin
          $error("effective_type: expected %0h, actual %0h", got_type, effective_type_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || result_valid_o) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= StallLimit) begin
        $display("variable_range_memory_type_lookup verification failed");
        $finish;
      end
    end
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/vrmt_pkg.sv
design/vrmt_cell.sv
design/variable_range_memory_type_lookup.sv
design/vrmt_checker.sv
sim/variable_range_memory_type_lookup_tb.sv
